// ===== src/bdio_pkg.sv =====
package bdio_pkg;

  // bus access codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  // 8K bank codes from address bits 15-13
  localparam logic [2:0] BANK_MAIN   = 3'd0;
  localparam logic [2:0] BANK_CART   = 3'd1;
  localparam logic [2:0] BANK_ROM_LO = 3'd6;
  localparam logic [2:0] BANK_ROM_HI = 3'd7;

  // i/o window 0xF8..0xFF, selected by address bits 2-0
  localparam logic [15:0] IO_BASE = 16'h00F8;
  localparam logic [2:0]  IO_KEY  = 3'd0;
  localparam logic [2:0]  IO_VID  = 3'd1;
  localparam logic [2:0]  IO_LINE = 3'd2;
  localparam logic [2:0]  IO_PAL  = 3'd3;
  localparam logic [2:0]  IO_TONE = 3'd4;
  localparam logic [2:0]  IO_VOL  = 3'd5;

  // fixed read values
  localparam logic [7:0] OPEN_BUS_BYTE = 8'hEE;
  localparam logic [7:0] VID_ID_BYTE   = 8'hFF;
  localparam logic [7:0] STATUS_BYTE   = 8'hF0;

  // system rom: 16K, indexed by address bits 13-0
  localparam int unsigned ROM_AW    = 14;
  localparam int unsigned ROM_DEPTH = 16384;

  // register reset values
  localparam logic [3:0] KBD_COL_RST  = 4'd3;
  localparam logic [7:0] VID_CTL_RST  = 8'h2E;
  localparam logic [3:0] PAL0_RST     = 4'd3;
  localparam logic [3:0] PAL1_RST     = 4'd14;
  localparam logic [3:0] PAL2_RST     = 4'd12;
  localparam logic [3:0] PAL3_RST     = 4'd1;
  localparam logic [7:0] TONE_DIV_RST = 8'h28;
  localparam logic [2:0] TONE_VOL_RST = 3'd3;

endpackage

// ===== src/bus_decode_and_io_registers_unit.sv =====
// bus decoder and i/o register block for an 8-bit cpu
//
// input channel: an access word (opcode, bus_address, write_data, key_row,
// video_line) is taken at a rising edge with start_i high and busy_o low.
// busy_o stays low: a new access may be started on every clock, so the block
// sustains one access per cycle.
// result channel: done_o is high for exactly one cycle, the cycle right after
// the access was taken, and the result word sits on the result ports in that
// cycle. the receiver cannot stall; results are never held.
// the result is delayed by the synchronous read port of the ram and rom
// memories: the address is registered at the accept edge and the read data is
// valid in the following cycle.
// main ram and cartridge ram share one memory (bank bit 13 picks the half);
// the system rom is a second memory written by rom-load accesses.
// reset clears the i/o registers to their power-on values and drops done_o.
// memory contents are not cleared; reading a never-written byte gives
// an unspecified value. BANK_BYTES may be any size from 1024 to 8192; a
// smaller bank mirrors inside its 8K window.
module bus_decode_and_io_registers_unit import bdio_pkg::*; #(
  parameter int unsigned BANK_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  key_row_i,
  input  logic [8:0]  video_line_i,
  output logic [7:0]  read_data_o,
  output logic [3:0]  keyboard_column_o,
  output logic [7:0]  video_control_o,
  output logic [15:0] palette_word_o,
  output logic [7:0]  tone_divider_o,
  output logic [2:0]  tone_volume_o
);

  localparam int unsigned OFF_W     = $clog2(BANK_BYTES);
  localparam int unsigned RAM_AW    = OFF_W + 1;
  localparam int unsigned RAM_DEPTH = 2 ** RAM_AW;
  localparam logic [15:0] BANK_X1   = 16'(BANK_BYTES);
  localparam logic [15:0] BANK_X2   = 16'(2 * BANK_BYTES);
  localparam logic [15:0] BANK_X4   = 16'(4 * BANK_BYTES);

  // where the read word of the current result comes from
  typedef enum logic [1:0] {
    SRC_IMM,
    SRC_RAM,
    SRC_ROM
  } rd_src_e;

  // memories
  logic [7:0] ram_mem [RAM_DEPTH];
  logic [7:0] rom_mem [ROM_DEPTH];
  logic [7:0] ram_rdata_q;
  logic [7:0] rom_rdata_q;

  // i/o registers
  logic [3:0] kbd_col_q, kbd_col_d;
  logic [7:0] vid_ctl_q, vid_ctl_d;
  logic [3:0] pal_q [4];
  logic [3:0] pal_d [4];
  logic [7:0] tone_div_q, tone_div_d;
  logic [2:0] tone_vol_q, tone_vol_d;

  // result stage
  logic       done_q;
  rd_src_e    src_q, src_d;
  logic [7:0] imm_q, imm_d;

  // decode
  logic              accept;
  logic [2:0]        bank;
  logic              is_io;
  logic [2:0]        io_sel;
  logic              is_read;
  logic              is_write;
  logic              ram_we;
  logic              rom_we;
  logic [15:0]       off_s0;
  logic [15:0]       off_s1;
  logic [15:0]       off_s2;
  logic [15:0]       off_s3;
  logic [RAM_AW-1:0] ram_addr;
  logic [ROM_AW-1:0] rom_addr;

  // every access completes in the cycle after it is taken
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign bank     = bus_address_i[15:13];
  assign is_io    = (bus_address_i[15:3] == IO_BASE[15:3]);
  assign io_sel   = bus_address_i[2:0];
  assign is_read  = (opcode_i == OP_READ);
  assign is_write = (opcode_i == OP_WRITE);

  // bank offset modulo BANK_BYTES: the 13-bit offset is below 8x the bank size,
  // so three compare and subtract steps (4x, 2x, 1x) leave the remainder
  assign off_s0 = {3'b000, bus_address_i[12:0]};
  assign off_s1 = (off_s0 >= BANK_X4) ? off_s0 - BANK_X4 : off_s0;
  assign off_s2 = (off_s1 >= BANK_X2) ? off_s1 - BANK_X2 : off_s1;
  assign off_s3 = (off_s2 >= BANK_X1) ? off_s2 - BANK_X1 : off_s2;

  // bank bit 13 splits main and cart ram; offset wraps inside the bank.
  // i/o addresses sit in bank 0, so their write-through lands in main ram
  assign ram_addr = {bus_address_i[13], off_s3[OFF_W-1:0]};
  assign rom_addr = bus_address_i[ROM_AW-1:0];

  // only the two ram banks accept bus writes; banks 2..7 ignore them
  assign ram_we = accept && is_write && (bank == BANK_MAIN || bank == BANK_CART);
  assign rom_we = accept && (opcode_i == OP_LOAD);

  // read source and immediate value for the result word
  always_comb begin
    src_d = SRC_IMM;
    imm_d = '0;
    if (is_read) begin
      if (is_io) begin
        unique case (io_sel)
          IO_KEY:  imm_d = key_row_i;
          IO_VID:  imm_d = VID_ID_BYTE;
          IO_LINE: imm_d = video_line_i[7:0];
          IO_PAL:  imm_d = STATUS_BYTE;
          default: src_d = SRC_RAM;  // 0xFC..0xFF read back main ram
        endcase
      end else begin
        unique case (bank)
          BANK_MAIN, BANK_CART:     src_d = SRC_RAM;
          BANK_ROM_LO, BANK_ROM_HI: src_d = SRC_ROM;
          default:                  imm_d = OPEN_BUS_BYTE;
        endcase
      end
    end
  end

  // i/o register updates
  always_comb begin
    kbd_col_d  = kbd_col_q;
    vid_ctl_d  = vid_ctl_q;
    pal_d      = pal_q;
    tone_div_d = tone_div_q;
    tone_vol_d = tone_vol_q;
    if (accept && is_write && is_io) begin
      unique case (io_sel)
        IO_KEY:  kbd_col_d = write_data_i[3:0];
        IO_VID:  vid_ctl_d = write_data_i;
        IO_PAL:  pal_d[write_data_i[5:4]] = write_data_i[3:0];
        IO_TONE: tone_div_d = write_data_i;
        IO_VOL:  tone_vol_d = write_data_i[7:5];
        default: ;  // line counter and 0xFE/0xFF only write through
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbd_col_q  <= KBD_COL_RST;
      vid_ctl_q  <= VID_CTL_RST;
      pal_q[0]   <= PAL0_RST;
      pal_q[1]   <= PAL1_RST;
      pal_q[2]   <= PAL2_RST;
      pal_q[3]   <= PAL3_RST;
      tone_div_q <= TONE_DIV_RST;
      tone_vol_q <= TONE_VOL_RST;
      done_q     <= 1'b0;
      src_q      <= SRC_IMM;
    end else begin
      kbd_col_q  <= kbd_col_d;
      vid_ctl_q  <= vid_ctl_d;
      pal_q      <= pal_d;
      tone_div_q <= tone_div_d;
      tone_vol_q <= tone_vol_d;
      done_q     <= accept;
      if (accept) begin
        src_q <= src_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      imm_q <= imm_d;
    end
  end

  // shared main/cart ram, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_addr] <= write_data_i;
    end
    if (accept) begin
      ram_rdata_q <= ram_mem[ram_addr];
    end
  end

  // system rom, written only by rom-load accesses
  always_ff @(posedge clk_i) begin
    if (rom_we) begin
      rom_mem[rom_addr] <= write_data_i;
    end
    if (accept) begin
      rom_rdata_q <= rom_mem[rom_addr];
    end
  end

  // result word: registers already show the state after the access
  always_comb begin
    unique case (src_q)
      SRC_RAM: read_data_o = ram_rdata_q;
      SRC_ROM: read_data_o = rom_rdata_q;
      default: read_data_o = imm_q;
    endcase
  end

  assign done_o            = done_q;
  assign keyboard_column_o = kbd_col_q;
  assign video_control_o   = vid_ctl_q;
  assign palette_word_o    = {pal_q[3], pal_q[2], pal_q[1], pal_q[0]};
  assign tone_divider_o    = tone_div_q;
  assign tone_volume_o     = tone_vol_q;

`ifndef SYNTHESIS
  // writes, loads and unused opcodes return a zero read word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(opcode_i != OP_READ) |-> read_data_o == '0)
    else $error("non-read access returned nonzero read data");

  // keyboard column only moves on a write to its i/o address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kbd_col_q != $past(kbd_col_q)) |->
      $past(accept && is_write && is_io && io_sel == IO_KEY))
    else $error("keyboard column changed without a write");

  // open-bus banks read back the fixed byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_read && !is_io && (bank[2:1] == 2'b01 || bank[2:1] == 2'b10)
      |=> done_o && read_data_o == OPEN_BUS_BYTE)
    else $error("open-bus read returned wrong byte");

  // rom is never written by an ordinary bus write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_we |-> opcode_i == OP_LOAD && !ram_we)
    else $error("rom and ram written by the same access");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench import bdio_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BANK = 8192;

  // one result word as the block presents it
  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  keyboard_column;
    logic [7:0]  video_control;
    logic [15:0] palette_word;
    logic [7:0]  tone_divider;
    logic [2:0]  tone_volume;
  } bus_word_t;

  // keeps a copy of memories and i/o registers, predicts each result word
  class io_bus_mirror;
    logic [7:0] main_mem [BANK];
    logic [7:0] cart_mem [BANK];
    logic [7:0] rom_mem [ROM_DEPTH];
    logic [3:0] kbd_col;
    logic [7:0] vid_ctl;
    logic [3:0] palette [4];
    logic [7:0] tone_div;
    logic [2:0] tone_vol;
    bus_word_t  pending_words [$];
    int unsigned mismatches;

    function new();
      kbd_col    = KBD_COL_RST;
      vid_ctl    = VID_CTL_RST;
      palette[0] = PAL0_RST;
      palette[1] = PAL1_RST;
      palette[2] = PAL2_RST;
      palette[3] = PAL3_RST;
      tone_div   = TONE_DIV_RST;
      tone_vol   = TONE_VOL_RST;
      mismatches = 0;
    endfunction

    function void predict_access(opcode_e op, logic [15:0] addr, logic [7:0] data,
                                 logic [7:0] row, logic [8:0] line);
      bus_word_t   w;
      int unsigned ofs;
      bit          is_io;
      ofs   = addr[12:0] % BANK;
      is_io = (addr >= IO_BASE) && (addr <= IO_BASE + 16'd7);
      w.read_data = 8'h00;
      case (op)
        OP_READ: begin
          if (is_io) begin
            case (addr[2:0])
              IO_KEY:  w.read_data = row;
              IO_VID:  w.read_data = VID_ID_BYTE;
              IO_LINE: w.read_data = line[7:0];
              IO_PAL:  w.read_data = STATUS_BYTE;
              default: w.read_data = main_mem[ofs];
            endcase
          end else begin
            case (addr[15:13])
              BANK_MAIN:               w.read_data = main_mem[ofs];
              BANK_CART:               w.read_data = cart_mem[ofs];
              BANK_ROM_LO, BANK_ROM_HI: w.read_data = rom_mem[addr[ROM_AW-1:0]];
              default:                 w.read_data = OPEN_BUS_BYTE;
            endcase
          end
        end
        OP_WRITE: begin
          if (is_io) begin
            case (addr[2:0])
              IO_KEY:  kbd_col = data[3:0];
              IO_VID:  vid_ctl = data;
              IO_PAL:  palette[data[5:4]] = data[3:0];
              IO_TONE: tone_div = data;
              IO_VOL:  tone_vol = data[7:5];
              default: ;
            endcase
            main_mem[ofs] = data;
          end else if (addr[15:13] == BANK_MAIN) begin
            main_mem[ofs] = data;
          end else if (addr[15:13] == BANK_CART) begin
            cart_mem[ofs] = data;
          end
        end
        OP_LOAD: rom_mem[addr[ROM_AW-1:0]] = data;
        default: ;
      endcase
      w.keyboard_column = kbd_col;
      w.video_control   = vid_ctl;
      w.palette_word    = {palette[3], palette[2], palette[1], palette[0]};
      w.tone_divider    = tone_div;
      w.tone_volume     = tone_vol;
      pending_words.push_back(w);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t ns: %s expected %0h got %0h", $time, field, want, got);
      end
    endfunction

    function void check_word(bus_word_t got);
      bus_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with nothing expected, read_data %0h",
                 $time, got.read_data);
        return;
      end
      want = pending_words.pop_front();
      compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
      compare_field("keyboard_column", 16'(want.keyboard_column), 16'(got.keyboard_column));
      compare_field("video_control", 16'(want.video_control), 16'(got.video_control));
      compare_field("palette_word", want.palette_word, got.palette_word);
      compare_field("tone_divider", 16'(want.tone_divider), 16'(got.tone_divider));
      compare_field("tone_volume", 16'(want.tone_volume), 16'(got.tone_volume));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  opcode_i;
  logic [15:0] bus_address_i;
  logic [7:0]  write_data_i;
  logic [7:0]  key_row_i;
  logic [8:0]  video_line_i;
  logic [7:0]  read_data_o;
  logic [3:0]  keyboard_column_o;
  logic [7:0]  video_control_o;
  logic [15:0] palette_word_o;
  logic [7:0]  tone_divider_o;
  logic [2:0]  tone_volume_o;

  io_bus_mirror bus_model = new();

  // stimulus-side record of written entries, so reads never touch unwritten memory
  bit          main_seen [BANK];
  bit          cart_seen [BANK];
  bit          rom_seen [ROM_DEPTH];
  int unsigned main_list [$];
  int unsigned cart_list [$];
  int unsigned rom_list [$];
  int unsigned words_sent = 0;

  bus_decode_and_io_registers_unit #(
    .BANK_BYTES(BANK)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .opcode_i         (opcode_i),
    .bus_address_i    (bus_address_i),
    .write_data_i     (write_data_i),
    .key_row_i        (key_row_i),
    .video_line_i     (video_line_i),
    .read_data_o      (read_data_o),
    .keyboard_column_o(keyboard_column_o),
    .video_control_o  (video_control_o),
    .palette_word_o   (palette_word_o),
    .tone_divider_o   (tone_divider_o),
    .tone_volume_o    (tone_volume_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // monitor: results from the previous word are checked before the word
  // taken at this edge is predicted; the queue keeps them in order anyway
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        bus_model.check_word({read_data_o, keyboard_column_o, video_control_o,
                              palette_word_o, tone_divider_o, tone_volume_o});
      if (start_i && !busy_o)
        bus_model.predict_access(opcode_e'(opcode_i), bus_address_i, write_data_i,
                                 key_row_i, video_line_i);
    end
  end

  // remember which entries a word will have written once it is taken
  function automatic void note_written(opcode_e op, logic [15:0] addr);
    int unsigned ofs;
    ofs = addr[12:0] % BANK;
    if (op == OP_LOAD) begin
      if (!rom_seen[addr[ROM_AW-1:0]]) begin
        rom_seen[addr[ROM_AW-1:0]] = 1'b1;
        rom_list.push_back(addr[ROM_AW-1:0]);
      end
    end else if (op == OP_WRITE && addr[15:13] == BANK_MAIN) begin
      // i/o writes sit in bank 0 and land in main ram as well
      if (!main_seen[ofs]) begin
        main_seen[ofs] = 1'b1;
        main_list.push_back(ofs);
      end
    end else if (op == OP_WRITE && addr[15:13] == BANK_CART) begin
      if (!cart_seen[ofs]) begin
        cart_seen[ofs] = 1'b1;
        cart_list.push_back(ofs);
      end
    end
  endfunction

  // idle gaps: mostly none or short, a few long, and gap-free stretches
  function automatic int unsigned draw_gap(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (n % 100 >= 70) return 0;
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drop start and put junk on the word fields while idle
  task automatic pause(int unsigned cycles);
    if (cycles != 0) begin
      start_i       <= 1'b0;
      opcode_i      <= 2'($urandom_range(0, 3));
      bus_address_i <= 16'($urandom);
      write_data_i  <= 8'($urandom);
      key_row_i     <= 8'($urandom);
      video_line_i  <= 9'($urandom);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // present one access word and hold it until taken, then maybe idle
  task automatic send_access(opcode_e op, logic [15:0] addr, logic [7:0] data,
                             logic [7:0] row, logic [8:0] line);
    note_written(op, addr);
    start_i       <= 1'b1;
    opcode_i      <= op;
    bus_address_i <= addr;
    write_data_i  <= data;
    key_row_i     <= row;
    video_line_i  <= line;
    do @(posedge clk_i); while (busy_o);
    pause(draw_gap(words_sent));
    words_sent++;
  endtask

  // read address that only hits written memory, i/o or open bus
  function automatic logic [15:0] pick_read_address();
    int unsigned region;
    int unsigned slot;
    int unsigned mirror;
    region = $urandom_range(0, 9);
    mirror = BANK * $urandom_range(0, 8192 / BANK - 1);
    if (region < 3) begin
      slot = $urandom_range(0, 7);
      // readback slots need their main ram byte written first
      if (slot >= 4 && !main_seen[IO_BASE + slot]) slot -= 4;
      return IO_BASE + 16'(slot);
    end
    if (region < 5 && main_list.size() != 0)
      return 16'(main_list[$urandom_range(0, main_list.size() - 1)] + mirror);
    if (region < 7 && cart_list.size() != 0)
      return 16'(16'h2000 + cart_list[$urandom_range(0, cart_list.size() - 1)] + mirror);
    if (region < 9 && rom_list.size() != 0)
      return {2'b11, 14'(rom_list[$urandom_range(0, rom_list.size() - 1)])};
    // open bus: banks 2..5
    return 16'(16'h4000 + $urandom_range(0, 16'h7FFF));
  endfunction

  // write address: mostly ram and i/o, some read-only banks
  function automatic logic [15:0] pick_write_address();
    int unsigned region;
    region = $urandom_range(0, 9);
    if (region < 4) return {BANK_MAIN, 13'($urandom)};
    if (region < 7) return {BANK_CART, 13'($urandom)};
    if (region < 9) return IO_BASE + 16'($urandom_range(0, 7));
    return {3'($urandom_range(2, 7)), 13'($urandom)};
  endfunction

  initial begin
    int unsigned kind;
    int unsigned waited;
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    opcode_i      <= OP_NONE;
    bus_address_i <= '0;
    write_data_i  <= '0;
    key_row_i     <= '0;
    video_line_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fixed i/o reads at reset register values, key row and line extremes
    send_access(OP_READ, IO_BASE + IO_KEY, 8'h00, 8'hFF, 9'h000);
    send_access(OP_READ, IO_BASE + IO_KEY, 8'hFF, 8'h00, 9'h1FF);
    send_access(OP_READ, IO_BASE + IO_VID, 8'h00, 8'hA5, 9'h0AA);
    send_access(OP_READ, IO_BASE + IO_LINE, 8'h00, 8'h5A, 9'h1FF);
    send_access(OP_READ, IO_BASE + IO_LINE, 8'h00, 8'h5A, 9'h100);
    send_access(OP_READ, IO_BASE + IO_PAL, 8'h00, 8'h00, 9'h000);
    // every i/o register, data extremes, palette first and last entry
    send_access(OP_WRITE, IO_BASE + IO_KEY, 8'hFF, 8'h00, 9'h000);
    send_access(OP_WRITE, IO_BASE + IO_VID, 8'h00, 8'h00, 9'h000);
    send_access(OP_WRITE, IO_BASE + IO_PAL, 8'hFF, 8'h00, 9'h000);
    send_access(OP_WRITE, IO_BASE + IO_PAL, 8'h00, 8'h00, 9'h000);
    send_access(OP_WRITE, IO_BASE + IO_TONE, 8'hFF, 8'h00, 9'h000);
    send_access(OP_WRITE, IO_BASE + IO_VOL, 8'hE0, 8'h00, 9'h000);
    // slots with no register still write main ram
    send_access(OP_WRITE, IO_BASE + IO_LINE, 8'h5A, 8'h00, 9'h000);
    send_access(OP_WRITE, 16'h00FF, 8'hA5, 8'h00, 9'h000);
    send_access(OP_READ, IO_BASE + IO_TONE, 8'h00, 8'h00, 9'h000);
    send_access(OP_READ, 16'h00FF, 8'h00, 8'h00, 9'h000);
    // ram bank edges, rom load index wraps, read-only banks ignore writes
    send_access(OP_WRITE, 16'h0000, 8'hFF, 8'h00, 9'h000);
    send_access(OP_WRITE, 16'h3FFF, 8'h55, 8'h00, 9'h000);
    send_access(OP_LOAD, 16'hFFFF, 8'h81, 8'h00, 9'h000);
    send_access(OP_LOAD, 16'h0000, 8'h7E, 8'h00, 9'h000);
    send_access(OP_WRITE, 16'hC000, 8'h11, 8'h00, 9'h000);
    send_access(OP_WRITE, 16'h4000, 8'h22, 8'h00, 9'h000);
    send_access(OP_READ, 16'h0000, 8'h00, 8'h00, 9'h000);
    send_access(OP_READ, 16'h3FFF, 8'h00, 8'h00, 9'h000);
    send_access(OP_READ, 16'hBFFF, 8'h00, 8'h00, 9'h000);
    send_access(OP_READ, 16'hC000, 8'h00, 8'h00, 9'h000);
    send_access(OP_READ, 16'hFFFF, 8'h00, 8'h00, 9'h000);
    send_access(OP_NONE, 16'hFFFF, 8'hFF, 8'hFF, 9'h1FF);

    // random words: writes and loads fill memory, reads only hit written bytes
    repeat (650) begin
      kind = $urandom_range(0, 99);
      if (kind < 30)
        send_access(OP_WRITE, pick_write_address(), 8'($urandom), 8'($urandom),
                    9'($urandom));
      else if (kind < 45)
        send_access(OP_LOAD, 16'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
      else if (kind < 94)
        send_access(OP_READ, pick_read_address(), 8'($urandom), 8'($urandom),
                    9'($urandom));
      else
        send_access(OP_NONE, 16'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
    end
    start_i <= 1'b0;

    // drain: results are never held, so a short bound is plenty
    waited = 0;
    while (bus_model.pending_words.size() != 0 && waited < 100) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);

    if (bus_model.mismatches == 0 && bus_model.pending_words.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bdio_pkg.sv
src/bus_decode_and_io_registers_unit.sv
tb/testbench.sv
